>>> rtl/life_generation_row_stencil_core_macros.svh
// assertion macros shared by the life row stencil rtl
`ifndef LIFE_GENERATION_ROW_STENCIL_CORE_MACROS_SVH
`define LIFE_GENERATION_ROW_STENCIL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising clock edge outside reset
`define LGRS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("life stencil check failed");
// next-cycle implication
`define LGRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("life stencil check failed");
`else
`define LGRS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define LGRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/lgrs_pkg.sv
// package: widths, types and helpers of the life row stencil
`timescale 1ns / 1ps
package lgrs_pkg;

   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = 64;
   localparam int ROWS_W     = 16;
   localparam int COLS_W     = 7;
   localparam int LANE_CELLS = 8;
   localparam int NUM_LANES  = ROW_W / LANE_CELLS;
   localparam int HALO_W     = LANE_CELLS + 2;
   localparam int PAD_W      = ROW_W + 2;
   localparam int NBR_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
   localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS = 2'd0,
      CSR_NUM_COLS = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]  mask;
      logic [ROWS_W-1:0] row_index;
      logic              frame_last;
   } row_meta_type;

   typedef struct packed {
      logic [ROW_W-1:0] up;
      logic [ROW_W-1:0] mid;
      logic [ROW_W-1:0] down;
      row_meta_type     meta;
   } job_type;

   // live-column mask, count capped at the board width
   function automatic logic [ROW_W-1:0] col_mask(input logic [COLS_W-1:0] cols);
      logic [ROW_W-1:0]  m;
      logic [COLS_W-1:0] c;
      c = (cols > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : cols;
      for (int j = 0; j < ROW_W; j++) begin
         m[j] = (COLS_W'(j) < c);
      end
      return m;
   endfunction

endpackage

>>> rtl/lgrs_lane.sv
// one lane: b3/s23 rule over a group of cells with a one-cell halo
`timescale 1ns / 1ps
module lgrs_lane
   import lgrs_pkg::*;
(
   input  logic [HALO_W-1:0]     up_bits,
   input  logic [HALO_W-1:0]     mid_bits,
   input  logic [HALO_W-1:0]     down_bits,
   output logic [LANE_CELLS-1:0] next_bits
);

   always_comb begin : cell_rule
      logic [NBR_W-1:0] n;
      for (int i = 0; i < LANE_CELLS; i++) begin
         n = NBR_W'(up_bits[i]) + NBR_W'(up_bits[i+1]) + NBR_W'(up_bits[i+2])
           + NBR_W'(mid_bits[i]) + NBR_W'(mid_bits[i+2])
           + NBR_W'(down_bits[i]) + NBR_W'(down_bits[i+1]) + NBR_W'(down_bits[i+2]);
         next_bits[i] = (n == BIRTH_COUNT) || (mid_bits[i+1] && (n == SURVIVE_COUNT));
      end
   end

endmodule

>>> rtl/lgrs_merge.sv
// merge stage: joins lane results into one masked row and holds it for the result port
`timescale 1ns / 1ps
`include "life_generation_row_stencil_core_macros.svh"
module lgrs_merge
   import lgrs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  logic [ROW_W-1:0]  lane_row,
   input  row_meta_type      meta,
   output logic              take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ROW_W-1:0]  rsp_next_row,
   output logic [ROWS_W-1:0] rsp_row_index,
   output logic              rsp_frame_last
);

   logic              valid_ff, valid_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROWS_W-1:0] index_ff;
   logic              last_ff;

   assign take     = job_valid && (!valid_ff || !rsp_stall);
   assign valid_in = take || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         row_ff   <= lane_row & meta.mask;
         index_ff <= meta.row_index;
         last_ff  <= meta.frame_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_next_row   = row_ff;
   assign rsp_row_index  = index_ff;
   assign rsp_frame_last = last_ff;

   // a held row is never overwritten
   `LGRS_ASSERT_NOW(a_no_overwrite, clock, reset, valid_ff && rsp_stall, !take)
   // an unmasked column never leaves the block
   `LGRS_ASSERT_NEXT(a_masked_out, clock, reset, take, (row_ff & ~$past(meta.mask)) == '0)

endmodule

>>> rtl/life_generation_row_stencil_core.sv
// top level: row window, job queue, parallel lanes and merge stage of the life row stencil
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------
//   req     | in        | req_valid/stall   | req_row_cells[63:0]
//   rsp     | out       | rsp_valid/stall   | rsp_next_row, rsp_row_index, rsp_frame_last
//   csr     | in        | csr_valid/ready   | csr_index[1:0], csr_wdata[15:0]
//
// one row transaction per cycle sustained while req_stall stays low; a result passes the
// job register, then the merge register; the final row of a multi-row frame gives two
// results and holds req_stall while the second one waits to enter the lanes
// eight lanes of eight cells each evaluate a whole 64-cell row combinationally
// synchronous reset clears the window, the row counter and valid flags; no clearing pass
// rsp_stall backs up through the merge register into the job register and then req_stall
`timescale 1ns / 1ps
`include "life_generation_row_stencil_core_macros.svh"
module life_generation_row_stencil_core
   import lgrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ROW_W-1:0]      req_row_cells,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROW_W-1:0]      rsp_next_row,
   output logic [ROWS_W-1:0]     rsp_row_index,
   output logic                  rsp_frame_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [ROWS_W-1:0] num_rows_ff, num_rows_in;
   logic [COLS_W-1:0] num_cols_ff, num_cols_in;

   // row window and frame position
   logic [ROW_W-1:0]  above_ff, above_in;
   logic [ROW_W-1:0]  middle_ff, middle_in;
   logic [ROWS_W-1:0] count_ff, count_in;

   // job register feeding the lanes, plus the second job of a frame end
   logic    j_valid_ff, j_valid_in;
   job_type j_ff, j_in;
   logic    p_valid_ff, p_valid_in;
   job_type p_ff, p_in;

   logic              accept;
   logic              j_take;
   logic              j_free;
   logic [ROW_W-1:0]  mask_now;
   logic [ROW_W-1:0]  row_m;
   logic [ROWS_W-1:0] rows_eff;
   logic [ROWS_W:0]   count_inc;
   logic              is_last;
   logic              job1_go, job2_go;
   job_type           job1, job2;

   logic [PAD_W-1:0]  up_pad, mid_pad, down_pad;
   logic [ROW_W-1:0]  lane_row;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_ROWS: num_rows_in = csr_wdata;
            CSR_NUM_COLS: num_cols_in = csr_wdata[COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= ROWS_W'(64);
         num_cols_ff <= COLS_W'(64);
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   // ---------------------------------------------------------------- window
   assign accept    = req_valid && !req_stall;
   assign mask_now  = col_mask(num_cols_ff);
   assign row_m     = req_row_cells & mask_now;
   // zero rows behaves as a one-row frame
   assign rows_eff  = (num_rows_ff == '0) ? ROWS_W'(1) : num_rows_ff;
   assign count_inc = {1'b0, count_ff} + (ROWS_W+1)'(1);
   assign is_last   = count_inc >= {1'b0, rows_eff};

   always_comb begin
      above_in  = above_ff;
      middle_in = middle_ff;
      count_in  = count_ff;
      job1_go   = 1'b0;
      job2_go   = 1'b0;

      // first job: next state of the row above the incoming one
      job1.up              = above_ff & mask_now;
      job1.mid             = middle_ff & mask_now;
      job1.down            = row_m;
      job1.meta.mask       = mask_now;
      job1.meta.row_index  = count_ff - ROWS_W'(1);
      job1.meta.frame_last = 1'b0;

      // second job: last row of the frame against a dead row below
      job2.up              = middle_ff & mask_now;
      job2.mid             = row_m;
      job2.down            = '0;
      job2.meta.mask       = mask_now;
      job2.meta.row_index  = count_ff;
      job2.meta.frame_last = 1'b1;

      if (accept) begin
         if (count_ff == '0) begin
            if (is_last) begin
               // single-row frame: dead rows above and below
               job1.up              = '0;
               job1.mid             = row_m;
               job1.down            = '0;
               job1.meta.row_index  = '0;
               job1.meta.frame_last = 1'b1;
               job1_go   = 1'b1;
               above_in  = '0;
               middle_in = '0;
               count_in  = '0;
            end else begin
               above_in  = '0;
               middle_in = row_m;
               count_in  = ROWS_W'(1);
            end
         end else begin
            job1_go = 1'b1;
            if (is_last) begin
               job2_go   = 1'b1;
               above_in  = '0;
               middle_in = '0;
               count_in  = '0;
            end else begin
               above_in  = middle_ff;
               middle_in = row_m;
               count_in  = count_inc[ROWS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff  <= '0;
         middle_ff <= '0;
         count_ff  <= '0;
      end else begin
         above_ff  <= above_in;
         middle_ff <= middle_in;
         count_ff  <= count_in;
      end
   end

   // ---------------------------------------------------------------- job queue
   assign j_free    = !j_valid_ff || j_take;
   // a pending second job takes the lanes before any new row
   assign req_stall = p_valid_ff || !j_free;

   always_comb begin
      j_valid_in = j_valid_ff && !j_take;
      j_in       = j_ff;
      p_valid_in = p_valid_ff;
      p_in       = p_ff;
      if (p_valid_ff && j_free) begin
         j_valid_in = 1'b1;
         j_in       = p_ff;
         p_valid_in = 1'b0;
      end else if (accept && job1_go) begin
         j_valid_in = 1'b1;
         j_in       = job1;
         if (job2_go) begin
            p_valid_in = 1'b1;
            p_in       = job2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         j_valid_ff <= j_valid_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      p_ff <= p_in;
   end

   // ---------------------------------------------------------------- lanes
   // dead column on each side of the board
   assign up_pad   = {1'b0, j_ff.up, 1'b0};
   assign mid_pad  = {1'b0, j_ff.mid, 1'b0};
   assign down_pad = {1'b0, j_ff.down, 1'b0};

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      lgrs_lane u_lane (
         .up_bits   (up_pad[g*LANE_CELLS +: HALO_W]),
         .mid_bits  (mid_pad[g*LANE_CELLS +: HALO_W]),
         .down_bits (down_pad[g*LANE_CELLS +: HALO_W]),
         .next_bits (lane_row[g*LANE_CELLS +: LANE_CELLS])
      );
   end

   // ---------------------------------------------------------------- merge
   lgrs_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (j_valid_ff),
      .lane_row       (lane_row),
      .meta           (j_ff.meta),
      .take           (j_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_row   (rsp_next_row),
      .rsp_row_index  (rsp_row_index),
      .rsp_frame_last (rsp_frame_last)
   );

   // ---------------------------------------------------------------- checks
   // a second job only waits behind the first job of the same frame end
   `LGRS_ASSERT_NOW(a_pend_behind_job, clock, reset, p_valid_ff, j_valid_ff && p_ff.meta.frame_last)
   // a row taken mid-frame always queues a job
   `LGRS_ASSERT_NEXT(a_row_makes_job, clock, reset, accept && (count_ff != '0), j_valid_ff)
   // the first row of a longer frame produces nothing
   `LGRS_ASSERT_NEXT(a_first_row_quiet, clock, reset, accept && !job1_go, !j_valid_ff && !p_valid_ff)
   // frame position always resets after a frame end
   `LGRS_ASSERT_NEXT(a_frame_end_clears, clock, reset, accept && is_last, count_ff == '0)

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the life row stencil: directed table, random frames, row predictor
`timescale 1ns / 1ps
module tb_top;
   import lgrs_pkg::*;

   // run shape
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 4;     // job register + merge register, with margin
   localparam int RANDOM_ROWS    = 550;
   localparam int QUIET_LIMIT    = 2000;  // cycles with no transaction on any channel
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_STEPS = 24;

   // one next-generation row as the result channel carries it
   typedef struct packed {
      logic [ROW_W-1:0]  cells;
      logic [ROWS_W-1:0] index;
      logic              frame_end;
   } gen_row_type;

   typedef enum bit {STEP_ROW, STEP_CSR} plan_kind_type;

   // a directed step is either a row or a register write; typed rows carry their result
   typedef struct {
      plan_kind_type    kind;
      csr_index_type    reg_sel;
      logic [ROW_W-1:0] value;
      bit               typed;
      gen_row_type      typed_row;
   } plan_step_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [ROW_W-1:0]      req_row_cells = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [ROW_W-1:0]      rsp_next_row;
   logic [ROWS_W-1:0]     rsp_row_index;
   logic                  rsp_frame_last;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index     = CSR_NUM_ROWS;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   // predictor copy of the registers and of the row window
   logic [ROWS_W-1:0] board_rows = ROWS_W'(64);
   logic [COLS_W-1:0] board_cols = COLS_W'(64);
   logic [ROW_W-1:0]  win_above  = '0;
   logic [ROW_W-1:0]  win_middle = '0;
   logic [ROWS_W-1:0] rows_seen  = '0;

   gen_row_type   next_gen_rows [$];  // rows the block still owes, oldest first
   int            mismatches = 0;
   gen_row_type   seen_row;
   gen_row_type   oldest_row;
   plan_step_type directed_plan [DIRECTED_STEPS];

   life_generation_row_stencil_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_cells  (req_row_cells),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_row   (rsp_next_row),
      .rsp_row_index  (rsp_row_index),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // columns in use as a bit mask; counts past the board width are capped
   function automatic logic [ROW_W-1:0] live_mask(input logic [COLS_W-1:0] cols);
      int n;
      n = (int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols);
      if (n >= ROW_W) return {ROW_W{1'b1}};
      return (ROW_W'(1) << n) - ROW_W'(1);
   endfunction

   // b3/s23 on one row, dead border on both sides and outside the mask
   function automatic logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] up,
                                                  input logic [ROW_W-1:0] mid,
                                                  input logic [ROW_W-1:0] down,
                                                  input logic [ROW_W-1:0] mask);
      logic [ROW_W+1:0] u, m, d;
      logic [ROW_W-1:0] nxt;
      int               live;
      u = {1'b0, up & mask, 1'b0};
      m = {1'b0, mid & mask, 1'b0};
      d = {1'b0, down & mask, 1'b0};
      for (int j = 0; j < ROW_W; j++) begin
         live = int'(u[j]) + int'(u[j+1]) + int'(u[j+2]) + int'(m[j]) + int'(m[j+2])
              + int'(d[j]) + int'(d[j+1]) + int'(d[j+2]);
         nxt[j] = (live == 3) || (m[j+1] && live == 2);
      end
      return nxt & mask;
   endfunction

   // one accepted row: results for the middle row, if any, and, at frame end, the row itself
   task automatic advance_board(input logic [ROW_W-1:0] cells,
                                output gen_row_type made [2], output int made_n);
      logic [ROW_W-1:0]  mask;
      logic [ROW_W-1:0]  row;
      logic [ROWS_W-1:0] span;
      bit                closes;
      mask   = live_mask(board_cols);
      row    = cells & mask;
      // zero rows behaves as a one-row frame
      span   = (board_rows == '0) ? ROWS_W'(1) : board_rows;
      closes = ({1'b0, rows_seen} + 17'd1) >= {1'b0, span};
      made_n = 0;
      if (rows_seen != '0) begin
         made[made_n] = '{evolve_row(win_above, win_middle, row, mask),
                          rows_seen - ROWS_W'(1), 1'b0};
         made_n++;
      end
      if (closes) begin
         // window is all zero on a single-row frame, so this covers that case too
         made[made_n] = '{evolve_row(win_middle, row, '0, mask), rows_seen, 1'b1};
         made_n++;
         win_above  = '0;
         win_middle = '0;
         rows_seen  = '0;
      end else begin
         win_above  = win_middle;
         win_middle = row;
         rows_seen  = rows_seen + ROWS_W'(1);
      end
   endtask

   // sender gap: none in a burst, else mostly short and now and then long
   function automatic int pick_gap(input bit burst);
      int p;
      if (burst) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [ROW_W-1:0] pick_cells();
      logic [ROW_W-1:0] a, b, c;
      int               p;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      p = $urandom_range(0, 99);
      if (p < 40) return a;
      if (p < 60) return a & b & c;
      if (p < 75) return a | b;
      // small live clusters anywhere along the row, edges included
      if (p < 87) return ROW_W'($urandom_range(1, 7)) << $urandom_range(0, ROW_W - 1);
      if (p < 93) return '0;
      return '1;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_rows_word();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return CSR_DATA_W'($urandom_range(1, 4));
      if (p < 75) return CSR_DATA_W'($urandom_range(5, 20));
      if (p < 83) return '0;
      if (p < 91) return '1;
      return CSR_DATA_W'($urandom);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_cols_word();
      logic [CSR_DATA_W-1:0] word;
      int                    p;
      int                    cols;
      p = $urandom_range(0, 99);
      if (p < 40)      cols = 64;
      else if (p < 65) cols = $urandom_range(1, 63);
      else if (p < 73) cols = 0;
      else if (p < 80) cols = 1;
      else if (p < 90) cols = $urandom_range(65, 127);
      else             cols = $urandom_range(2, 8);
      word = CSR_DATA_W'(cols);
      // bits above the column field are don't-care
      if ($urandom_range(0, 3) == 0)
         word[CSR_DATA_W-1:COLS_W] = (CSR_DATA_W-COLS_W)'($urandom);
      return word;
   endfunction

   // drive one row transaction and queue what it should produce
   task automatic send_row(input logic [ROW_W-1:0] cells, input bit typed,
                           input gen_row_type typed_row, input bit burst);
      gen_row_type made [2];
      int          made_n;
      int          gap;
      gap = pick_gap(burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays high when rows follow back to back
      req_valid     <= 1'b1;
      req_row_cells <= cells;
      do @(posedge clock); while (req_stall);
      advance_board(cells, made, made_n);
      if (typed) begin
         next_gen_rows.push_back(typed_row);
      end else begin
         for (int k = 0; k < made_n; k++) next_gen_rows.push_back(made[k]);
      end
   endtask

   // register write; csr_valid is left high so writes can go back to back
   task automatic write_csr(input csr_index_type sel, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         CSR_NUM_ROWS: begin
            board_rows = data;
         end
         CSR_NUM_COLS: begin
            board_cols = data[COLS_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // stop sending, let every owed row come back, then give the pipeline time to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (next_gen_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input gen_row_type want,
                                input gen_row_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch, %s: expected row %h index %0d last %0b, got row %h index %0d last %0b",
                  what, want.cells, want.index, want.frame_end,
                  got.cells, got.index, got.frame_end);
      end
   endtask

   // result side back-pressure: runs of ready, short stalls and the odd long one
   initial begin : rsp_backpressure
      int p;
      int run;
      forever begin
         p = $urandom_range(0, 99);
         if (p < 55) begin
            rsp_stall <= 1'b0;
            run = $urandom_range(1, 20);
         end else if (p < 92) begin
            rsp_stall <= 1'b1;
            run = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            run = $urandom_range(10, 25);
         end
         repeat (run) @(posedge clock);
      end
   end

   // compare each result transaction with the oldest owed row
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_row = '{rsp_next_row, rsp_row_index, rsp_frame_last};
         if (next_gen_rows.size() == 0) begin
            note_mismatch("unexpected result", '0, seen_row);
         end else begin
            oldest_row = next_gen_rows.pop_front();
            if (seen_row.cells !== oldest_row.cells)
               note_mismatch("next_row", oldest_row, seen_row);
            else if (seen_row.index !== oldest_row.index)
               note_mismatch("row_index", oldest_row, seen_row);
            else if (seen_row.frame_end !== oldest_row.frame_end)
               note_mismatch("frame_last", oldest_row, seen_row);
         end
      end
   end

   // hang guard: too long with no transaction on any channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout, %0d rows still owed", next_gen_rows.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int random_rows;
      int phase_rows;
      int span;
      bit burst;

      // reset state is a 64 x 64 frame; the opening rows run inside it
      directed_plan = '{
         '{STEP_ROW, CSR_NUM_ROWS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'h0000_0000_0000_0000, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'h8000_0000_0000_0001, 1'b0, '0},
         // shrink the frame below the rows already seen: next row closes it
         '{STEP_CSR, CSR_NUM_ROWS, 64'd2, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
         // single-row frames: only the row's own neighbours count
         '{STEP_CSR, CSR_NUM_ROWS, 64'd1, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h7FFF_FFFF_FFFF_FFFE, 16'd0, 1'b1}},
         '{STEP_ROW, CSR_NUM_ROWS, 64'h0000_0000_0000_0000, 1'b1,
           '{64'h0000_0000_0000_0000, 16'd0, 1'b1}},
         // no columns: everything dead
         '{STEP_CSR, CSR_NUM_COLS, 64'd0, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h0000_0000_0000_0000, 16'd0, 1'b1}},
         // one column: a lone cell always dies
         '{STEP_CSR, CSR_NUM_COLS, 64'd1, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h0000_0000_0000_0000, 16'd0, 1'b1}},
         // column count past the board width caps at 64, zero rows acts as one
         '{STEP_CSR, CSR_NUM_COLS, 64'd127, 1'b0, '0},
         '{STEP_CSR, CSR_NUM_ROWS, 64'd0, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h7FFF_FFFF_FFFF_FFFE, 16'd0, 1'b1}},
         // narrow three-row frame with junk above the used columns
         '{STEP_CSR, CSR_NUM_ROWS, 64'd3, 1'b0, '0},
         '{STEP_CSR, CSR_NUM_COLS, 64'd5, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'hFFFF_FFFF_FFFF_FFC2, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'h0000_0000_0000_0002, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'h5555_5555_5555_5552, 1'b0, '0},
         // tallest frame, full width
         '{STEP_CSR, CSR_NUM_ROWS, 64'd65535, 1'b0, '0},
         '{STEP_CSR, CSR_NUM_COLS, 64'd64, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'h5555_5555_5555_5555, 1'b0, '0},
         '{STEP_ROW, CSR_NUM_ROWS, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k]) begin
         if (directed_plan[k].kind == STEP_CSR) begin
            settle();
            write_csr(directed_plan[k].reg_sel, directed_plan[k].value[CSR_DATA_W-1:0]);
            csr_valid <= 1'b0;
         end else begin
            send_row(directed_plan[k].value, directed_plan[k].typed,
                     directed_plan[k].typed_row, 1'b0);
         end
      end

      // random phases: reprogram while idle, then a run of rows that may stop mid-frame
      random_rows = 0;
      while (random_rows < RANDOM_ROWS) begin
         settle();
         if ($urandom_range(0, 3) != 0) write_csr(CSR_NUM_ROWS, pick_rows_word());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_NUM_COLS, pick_cols_word());
         csr_valid <= 1'b0;
         burst = ($urandom_range(0, 3) == 0);
         span  = (board_rows == '0) ? 1 : int'(board_rows);
         if (span <= 12) begin
            // mostly whole frames, sometimes a partial one left open
            phase_rows = span * $urandom_range(1, 4);
            if ($urandom_range(0, 4) == 0) phase_rows += $urandom_range(1, span);
         end else begin
            phase_rows = $urandom_range(4, 40);
         end
         repeat (phase_rows) send_row(pick_cells(), 1'b0, '0, burst);
         random_rows += phase_rows;
      end

      settle();
      if (mismatches == 0 && next_gen_rows.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/lgrs_pkg.sv
rtl/lgrs_lane.sv
rtl/lgrs_merge.sv
rtl/life_generation_row_stencil_core.sv
bench/tb_top.sv
